FILE: sv/stdf_pkg.sv
package stdf_pkg;

  // Default geometry of the display and the text store.
  localparam int DISPLAY_WIDTH_DEF = 16;
  localparam int TEXT_DEPTH_DEF    = 64;

  // Fixed field widths.
  localparam int TL_W     = 6;
  localparam int LP_W     = 8;
  localparam int IDX_W    = 6;
  localparam int CHAR_W   = 8;
  localparam int SAMPLE_W = 10;
  localparam int TICK_W   = 8;
  localparam int PROD_W   = 18;
  localparam int TL_MAX   = 63;

  // Configuration port geometry.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Display codes.
  localparam logic [CHAR_W-1:0] HOME_CMD   = 8'h80;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  // Scroll period is floor(sample * SPEED_SCALE / SPEED_FULL) + PERIOD_BASE.
  localparam int SPEED_SCALE = 150;
  localparam int SPEED_FULL  = 1023;
  localparam int PERIOD_BASE = 50;

  // Register reset values.
  localparam logic [TL_W-1:0] TEXT_LENGTH_RST = 6'd26;
  localparam logic [LP_W-1:0] LED_PERIOD_RST  = 8'd100;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_PAUSE = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_TEXT_LENGTH = 1'b0,
    REG_LED_PERIOD  = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]          command;
    logic [SAMPLE_W-1:0] speed_sample;
    logic [IDX_W-1:0]    char_index;
    logic [CHAR_W-1:0]   char_value;
  } stdf_in_t;

  typedef struct packed {
    logic              lcd_valid;
    logic [CHAR_W-1:0] lcd_byte;
    logic              led;
  } stdf_out_t;

endpackage

FILE: sv/stdf_ram.sv
module stdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; the read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/scrolling_text_display_feeder.sv
// Scrolling text feeder for a character display.
// Input channel (in_valid_i/in_ready_o, in_data_i): one beat carries a command.
// A tick produces exactly one result beat; a load writes one character into
// the text store and a pause toggle freezes or resumes scrolling, neither giving a result.
// Output channel (out_valid_o/out_ready_i, out_data_o): one beat per tick with
// the display byte (or none, flagged by lcd_valid) and the LED level.
// A tick's result passes through the read stage, where the text store is read,
// and then through the output register.
// Throughput: one beat per cycle while the receiver takes results and no remainder
// pass runs; the state update of a tick completes in the cycle it is accepted, and
// the text store's write and read ports serve either one load or one tick read per cycle.
// Writing text_length starts a remainder pass over the scroll offset, with one
// restoring step per offset bit, during which no beat is accepted.
// Reset clears the scroll, column and LED counters and restores the register
// defaults; the text store is not cleared and must be loaded before use.
// When the receiver stalls, the output register holds its beat, one more tick
// waits in the read stage, and in_ready_o then falls until the beat is taken.
module scrolling_text_display_feeder #(
  parameter int DISPLAY_WIDTH = stdf_pkg::DISPLAY_WIDTH_DEF,
  parameter int TEXT_DEPTH    = stdf_pkg::TEXT_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  stdf_pkg::stdf_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output stdf_pkg::stdf_out_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stdf_pkg::APB_AW-1:0]   paddr,
  input  logic [stdf_pkg::APB_DW-1:0]   pwdata,
  output logic [stdf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  import stdf_pkg::*;

  localparam int COL_W      = $clog2(DISPLAY_WIDTH + 1);
  localparam int CYC_W      = $clog2(TL_MAX + DISPLAY_WIDTH);
  localparam int STEP_W     = (CYC_W > 1) ? $clog2(CYC_W) : 1;
  localparam int AW         = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int WRAP_W     = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int WRAP_STEPS = ((1 << IDX_W) + TEXT_DEPTH - 1) / TEXT_DEPTH;
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(DISPLAY_WIDTH);
  localparam logic [CYC_W-1:0] CYC_EXTRA = CYC_W'(DISPLAY_WIDTH - 1);

  // Wraps a text position into the store depth by repeated subtraction.
  function automatic logic [AW-1:0] wrap_index(input logic [IDX_W-1:0] idx);
    logic [WRAP_W-1:0] v;
    v = WRAP_W'(idx);
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (v >= WRAP_W'(TEXT_DEPTH)) begin
        v = v - WRAP_W'(TEXT_DEPTH);
      end
    end
    return v[AW-1:0];
  endfunction

  // Configuration registers.
  logic [TL_W-1:0] text_length_q;
  logic [LP_W-1:0] led_period_q;
  logic            cfg_we;
  logic            cfg_tl_we;

  // Scroll and display state.
  logic [CYC_W-1:0]  offset_q, offset_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              fill_q, fill_d;
  logic              moving_q, moving_d;
  logic [TICK_W-1:0] scroll_q, scroll_d;
  logic [TICK_W-1:0] ledt_q, ledt_d;
  logic              led_q, led_d;

  // Offset remainder pass.
  logic                norm_busy_q;
  logic [STEP_W-1:0]   norm_step_q;
  logic [CYC_W-1:0]    norm_rem_q;
  logic [2*CYC_W-1:0]  norm_div;
  logic                norm_ge;
  logic [CYC_W-1:0]    norm_rem_next;
  logic                norm_done;

  // Read stage and output register.
  logic              s1_valid_q;
  logic              s1_lcd_valid_q;
  logic              s1_text_q;
  logic [CHAR_W-1:0] s1_byte_q;
  logic              s1_led_q;
  logic              s1_adv;
  logic              out_valid_q;
  stdf_out_t         out_q;

  // Handshake and per-tick datapath.
  logic              in_fire;
  logic              tick_fire;
  logic              load_fire;
  logic [CYC_W-1:0]  cycle_len;
  logic [CYC_W:0]    pos_sum;
  logic [CYC_W:0]    pos_wide;
  logic [CYC_W-1:0]  pos;
  logic              pos_text;
  logic              disp_valid;
  logic              disp_text;
  logic [CHAR_W-1:0] disp_byte;
  logic [PROD_W-1:0] speed_prod;
  logic [PROD_W-1:0] speed_lim;
  logic              scroll_hit;
  logic [CYC_W-1:0]  offset_inc;
  logic              led_hit;
  logic [CHAR_W-1:0] ram_rdata;

  assign cycle_len = CYC_W'(text_length_q) + CYC_EXTRA;

  // Configuration port: always ready, writes on the access phase.
  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign cfg_tl_we = cfg_we && (paddr[2] == REG_TEXT_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_length_q <= TEXT_LENGTH_RST;
      led_period_q  <= LED_PERIOD_RST;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_TEXT_LENGTH: text_length_q <= pwdata[TL_W-1:0];
        REG_LED_PERIOD:  led_period_q  <= pwdata[LP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TEXT_LENGTH: prdata = APB_DW'(text_length_q);
      REG_LED_PERIOD:  prdata = APB_DW'(led_period_q);
      default:         prdata = '0;
    endcase
  end

  // Input handshake: a beat enters when no remainder pass runs and the read stage is free or moving on.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !norm_busy_q && (!s1_valid_q || s1_adv);
  assign in_fire    = in_valid_i && in_ready_o;
  assign tick_fire  = in_fire && (in_data_i.command == CMD_TICK);
  assign load_fire  = in_fire && (in_data_i.command == CMD_LOAD);

  // Window position of the current column, kept below the cycle length.
  assign pos_sum  = {1'b0, offset_q} + (CYC_W + 1)'(col_q);
  assign pos_wide = (pos_sum >= {1'b0, cycle_len}) ? pos_sum - {1'b0, cycle_len} : pos_sum;
  assign pos      = pos_wide[CYC_W-1:0];
  assign pos_text = pos < CYC_W'(text_length_q);

  // Scroll test: count+1 reaches the period exactly when
  // sample*150 < (count-48)*1023 with count at least 49.
  assign speed_prod = PROD_W'(in_data_i.speed_sample) * PROD_W'(SPEED_SCALE);
  assign speed_lim  = PROD_W'(scroll_q - TICK_W'(PERIOD_BASE - 2)) * PROD_W'(SPEED_FULL);
  assign scroll_hit = (scroll_q >= TICK_W'(PERIOD_BASE - 1)) && (speed_prod < speed_lim);

  assign offset_inc = offset_q + CYC_W'(1);
  assign led_hit    = ((TICK_W + 1)'(ledt_q) + (TICK_W + 1)'(1)) >= (TICK_W + 1)'(led_period_q);

  // Next state: a tick's display, scroll and LED steps, in that order, or a pause toggle.
  always_comb begin
    offset_d   = offset_q;
    col_d      = col_q;
    fill_d     = fill_q;
    moving_d   = moving_q;
    scroll_d   = scroll_q;
    ledt_d     = ledt_q;
    led_d      = led_q;
    disp_valid = 1'b0;
    disp_text  = 1'b0;
    disp_byte  = '0;
    if (in_fire) begin
      case (in_data_i.command)
        CMD_TICK: begin
          if (col_q == COL_LAST) begin
            fill_d     = 1'b0;
            col_d      = '0;
            disp_valid = 1'b1;
            disp_byte  = HOME_CMD;
          end else if (fill_q) begin
            disp_valid = 1'b1;
            disp_text  = pos_text;
            disp_byte  = pos_text ? '0 : BLANK_CHAR;
            col_d      = col_q + COL_W'(1);
          end
          if (scroll_hit) begin
            scroll_d = '0;
            if (moving_q) begin
              fill_d   = 1'b1;
              offset_d = (offset_inc >= cycle_len) ? '0 : offset_inc;
            end
          end else begin
            scroll_d = scroll_q + TICK_W'(1);
          end
          if (led_hit) begin
            ledt_d = '0;
            led_d  = !led_q;
          end else begin
            ledt_d = ledt_q + TICK_W'(1);
          end
        end
        CMD_PAUSE: moving_d = !moving_q;
        default: ;
      endcase
    end
  end

  // Remainder pass: one restoring step per cycle, from the top bit down.
  assign norm_div      = (2 * CYC_W)'(cycle_len) << norm_step_q;
  assign norm_ge       = (2 * CYC_W)'(norm_rem_q) >= norm_div;
  assign norm_rem_next = norm_ge ? norm_rem_q - norm_div[CYC_W-1:0] : norm_rem_q;
  assign norm_done     = norm_busy_q && (norm_step_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_busy_q <= 1'b0;
      norm_step_q <= '0;
    end else if (cfg_tl_we) begin
      norm_busy_q <= 1'b1;
      norm_step_q <= STEP_W'(CYC_W - 1);
    end else if (norm_busy_q) begin
      norm_busy_q <= !norm_done;
      norm_step_q <= norm_step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_tl_we) begin
      norm_rem_q <= offset_q;
    end else if (norm_busy_q) begin
      norm_rem_q <= norm_rem_next;
    end
  end

  // Scroll, display and LED state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      col_q    <= '0;
      fill_q   <= 1'b1;
      moving_q <= 1'b1;
      scroll_q <= '0;
      ledt_q   <= '0;
      led_q    <= 1'b0;
    end else begin
      offset_q <= norm_done ? norm_rem_next : offset_d;
      col_q    <= col_d;
      fill_q   <= fill_d;
      moving_q <= moving_d;
      scroll_q <= scroll_d;
      ledt_q   <= ledt_d;
      led_q    <= led_d;
    end
  end

  // Text store: one load or one tick read per cycle.
  stdf_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (wrap_index(in_data_i.char_index)),
    .wdata_i (in_data_i.char_value),
    .re_i    (tick_fire && disp_text),
    .raddr_i (wrap_index(pos[IDX_W-1:0])),
    .rdata_o (ram_rdata)
  );

  // Read stage: waits for the text byte alongside the tick's other results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (tick_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      s1_lcd_valid_q <= disp_valid;
      s1_text_q      <= disp_text;
      s1_byte_q      <= disp_byte;
      s1_led_q       <= led_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.lcd_valid <= s1_lcd_valid_q;
      out_q.lcd_byte  <= s1_text_q ? ram_rdata : s1_byte_q;
      out_q.led       <= s1_led_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/stdf_checker.sv
module stdf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input stdf_pkg::stdf_in_t            in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input stdf_pkg::stdf_out_t           out_data_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [stdf_pkg::APB_AW-1:0]   paddr,
  input logic                          pready
);

  import stdf_pkg::*;

  logic tick_beat;
  logic tl_write;

  assign tick_beat = in_valid_i && in_ready_o && (in_data_i.command == CMD_TICK);
  assign tl_write  = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_LENGTH);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // A beat without a display byte carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.lcd_valid |-> out_data_o.lcd_byte == '0)
    else $error("idle display beat carries a non-zero byte");

  // A text length write holds off input while the offset is reduced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tl_write |=> !in_ready_o)
    else $error("input accepted during offset reduction");

  // A fresh result beat traces back to an accepted tick through the read stage and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(tick_beat, 2))
    else $error("result beat without a preceding tick");

endmodule

bind scrolling_text_display_feeder stdf_checker u_stdf_checker (.*);

FILE: tb/sv/tb_scrolling_text_display_feeder.sv
module tb_scrolling_text_display_feeder;
  timeunit 1ns;
  timeprecision 1ps;

  import stdf_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int DW         = DISPLAY_WIDTH_DEF;
  localparam int TD         = TEXT_DEPTH_DEF;
  localparam int SETTLE     = 12;
  localparam int PHASE_LEN  = 88;
  localparam int TIMEOUT_NS = 5_000_000;

  // The command field has one code that the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Speed profiles for stretches of random beats.
  localparam int SPD_FAST = 0;
  localparam int SPD_SLOW = 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  stdf_in_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  stdf_out_t  out_data_o;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  scrolling_text_display_feeder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Command beats waiting to be sent, and display beats still owed by the block.
  stdf_in_t  cmd_pend_q[$];
  stdf_out_t lcd_expect_q[$];

  // Mirror of the marquee state and its registers.
  logic [CHAR_W-1:0] text_mem [TD];
  logic [TL_W-1:0]   text_len;
  logic [LP_W-1:0]   led_per;
  int                win_ofs;
  int                col_pos;
  bit                filling;
  bit                scrolling;
  int                scroll_cnt;
  int                led_cnt;
  bit                led_lvl;

  int errors    = 0;
  int n_ticks   = 0;
  int n_loads   = 0;
  int n_pauses  = 0;
  int n_results = 0;
  int n_home    = 0;
  int n_scrolls = 0;
  int n_cfg     = 0;

  bit in_took = 1'b0;

  // Advance the marquee by one command beat; returns 1 when a display beat is due.
  function automatic bit marquee_step(input stdf_in_t beat, output stdf_out_t res);
    int cyc;
    int pos;
    int period;
    res = '0;
    cyc = int'(text_len) + DW - 1;
    if (beat.command == CMD_LOAD) begin
      text_mem[beat.char_index] = beat.char_value;
      n_loads++;
      return 1'b0;
    end
    if (beat.command == CMD_PAUSE) begin
      scrolling = !scrolling;
      n_pauses++;
      return 1'b0;
    end
    if (beat.command != CMD_TICK) begin
      return 1'b0;
    end
    n_ticks++;

    // A full row is closed with cursor-home, then the row stays quiet.
    if (col_pos == DW) begin
      filling = 1'b0;
      col_pos = 0;
      res.lcd_valid = 1'b1;
      res.lcd_byte = HOME_CMD;
      n_home++;
    end else if (filling) begin
      pos = (win_ofs + col_pos) % cyc;
      res.lcd_byte = (pos < int'(text_len)) ? text_mem[pos % TD] : BLANK_CHAR;
      res.lcd_valid = 1'b1;
      col_pos++;
    end

    // Scroll period follows this tick's speed reading.
    period = int'(beat.speed_sample) * SPEED_SCALE / SPEED_FULL + PERIOD_BASE;
    scroll_cnt++;
    if (scroll_cnt >= period) begin
      if (scrolling) begin
        filling = 1'b1;
        win_ofs = (win_ofs + 1) % cyc;
        n_scrolls++;
      end
      scroll_cnt = 0;
    end

    led_cnt++;
    if (led_cnt >= int'(led_per)) begin
      led_lvl = !led_lvl;
      led_cnt = 0;
    end
    res.led = led_lvl;
    return 1'b1;
  endfunction

  // Check each display beat against the oldest expectation, then record accepted commands.
  always @(posedge clk_i) begin
    stdf_out_t want;
    stdf_out_t got;
    in_took = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        n_results++;
        if (lcd_expect_q.size() == 0) begin
          $error("display beat with nothing expected: %p", got);
          errors++;
        end else begin
          want = lcd_expect_q.pop_front();
          if (got.lcd_valid !== want.lcd_valid) begin
            $error("lcd_valid mismatch: expected %0d, actual %0d", want.lcd_valid, got.lcd_valid);
            errors++;
          end
          if (got.lcd_byte !== want.lcd_byte) begin
            $error("lcd_byte mismatch: expected 0x%02h, actual 0x%02h", want.lcd_byte, got.lcd_byte);
            errors++;
          end
          if (got.led !== want.led) begin
            $error("led mismatch: expected %0d, actual %0d", want.led, got.led);
            errors++;
          end
        end
      end
      in_took = in_valid_i && in_ready_o;
      if (in_took && marquee_step(in_data_i, want)) begin
        lcd_expect_q.push_back(want);
      end
    end
  end

  // Sender: bursts of beats separated by random gaps, some bursts back to back.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_pend_q.size() > 0) begin
        in_data_i <= cmd_pend_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: switches between always ready, random, periodic and mostly stalled.
  int  stall_mode = 0;
  int  stall_left = 0;
  logic take_next;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: take_next = 1'b1;
      1: take_next = ($urandom_range(0, 1) == 1);
      2: take_next = (stall_left % 4) != 0;
      default: take_next = ($urandom_range(0, 7) == 0);
    endcase
    out_ready_i <= take_next;
  end

  // Register write followed by a read-back, only while the block is idle.
  task automatic reg_write(input reg_e idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rd;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_TEXT_LENGTH) begin
      text_len = value[TL_W-1:0];
    end else begin
      led_per = value[LP_W-1:0];
    end
    n_cfg++;
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== value) begin
      $error("register %s read-back mismatch: expected 0x%0h, actual 0x%0h",
             idx.name(), value, rd);
      errors++;
    end
  endtask

  // Hold off until every queued beat is sent and every display beat has arrived.
  task automatic drain();
    while (cmd_pend_q.size() != 0 || in_valid_i || lcd_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic stdf_in_t make_beat(input logic [1:0] cmd, input int sample,
                                         input int idx, input int chr);
    stdf_in_t b;
    b.command = cmd;
    b.speed_sample = SAMPLE_W'(sample);
    b.char_index = IDX_W'(idx);
    b.char_value = CHAR_W'(chr);
    return b;
  endfunction

  // Mostly ticks, with loads and pause toggles mixed in and the odd unused code.
  function automatic stdf_in_t rand_beat(input int spd);
    stdf_in_t b;
    int pick;
    b = make_beat(CMD_TICK, $urandom_range(0, 1023), $urandom_range(0, 63),
                  $urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick >= 97) begin
      b.command = CMD_UNUSED;
    end else if (pick >= 93) begin
      b.command = CMD_PAUSE;
    end else if (pick >= 84) begin
      b.command = CMD_LOAD;
    end
    if (spd == SPD_FAST) begin
      b.speed_sample = SAMPLE_W'($urandom_range(0, 6));
    end else if (spd == SPD_SLOW) begin
      b.speed_sample = SAMPLE_W'($urandom_range(1017, 1023));
    end
    return b;
  endfunction

  // Queue a phase of random beats in stretches of one speed profile each.
  task automatic queue_random(input int count);
    stdf_in_t b;
    int made;
    int spd;
    int stretch;
    made = 0;
    stretch = 0;
    spd = 0;
    while (made < count) begin
      if (stretch == 0) begin
        spd = $urandom_range(0, 2);
        stretch = $urandom_range(20, 60);
      end
      stretch--;
      b = rand_beat(spd);
      cmd_pend_q.push_back(b);
      if (b.command != CMD_UNUSED) begin
        made++;
      end
    end
  endtask

  localparam int N_SAMPLES = 6;
  localparam int SAMPLE_SET [N_SAMPLES] = '{0, 1023, 'h155, 'h2AA, 1, 1022};

  initial begin
    text_len   = TEXT_LENGTH_RST;
    led_per    = LED_PERIOD_RST;
    win_ofs    = 0;
    col_pos    = 0;
    filling    = 1'b1;
    scrolling  = 1'b1;
    scroll_cnt = 0;
    led_cnt    = 0;
    led_lvl    = 1'b0;
    foreach (text_mem[i]) text_mem[i] = '0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole text store first so that no tick reads an empty entry.
    for (int i = 0; i < TD; i++) begin
      cmd_pend_q.push_back(make_beat(CMD_LOAD, 0, i,
        (i == 0) ? 0 : (i == 1) ? 255 : $urandom_range(0, 255)));
    end

    // Directed: unused code, a full row with cursor-home, speed extremes, pause.
    cmd_pend_q.push_back(make_beat(CMD_UNUSED, 1023, 63, 255));
    for (int i = 0; i < 18; i++) begin
      cmd_pend_q.push_back(make_beat(CMD_TICK, SAMPLE_SET[i % N_SAMPLES], 0, 0));
    end
    cmd_pend_q.push_back(make_beat(CMD_PAUSE, 0, 0, 0));
    cmd_pend_q.push_back(make_beat(CMD_TICK, 0, 0, 0));
    cmd_pend_q.push_back(make_beat(CMD_PAUSE, 1023, 63, 255));
    cmd_pend_q.push_back(make_beat(CMD_LOAD, 1023, 63, 0));
    cmd_pend_q.push_back(make_beat(CMD_TICK, 1023, 63, 255));
    drain();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;
        1: begin
          reg_write(REG_TEXT_LENGTH, 1);
          reg_write(REG_LED_PERIOD, 1);
        end
        2: begin
          reg_write(REG_TEXT_LENGTH, TL_MAX);
          reg_write(REG_LED_PERIOD, 255);
        end
        3: begin
          // Empty text gives an all-blank row; a zero period toggles the LED every tick.
          reg_write(REG_TEXT_LENGTH, 0);
          reg_write(REG_LED_PERIOD, 0);
        end
        4: begin
          reg_write(REG_TEXT_LENGTH, $urandom_range(2, 6));
          reg_write(REG_LED_PERIOD, $urandom_range(2, 10));
        end
        default: begin
          reg_write(REG_TEXT_LENGTH, $urandom_range(0, TL_MAX));
          reg_write(REG_LED_PERIOD, $urandom_range(0, 255));
        end
      endcase
      queue_random(PHASE_LEN);
      drain();
    end

    if (lcd_expect_q.size() != 0) begin
      $error("%0d display beats never arrived", lcd_expect_q.size());
      errors++;
    end
    $display("Run covered %0d ticks, %0d text loads and %0d pause toggles with %0d register writes.",
             n_ticks, n_loads, n_pauses, n_cfg);
    $display("Checked %0d display beats, %0d of them cursor-home, across %0d scroll steps.",
             n_results, n_home, n_scrolls);
    if (errors == 0) begin
      $display("PASS scrolling_text_display_feeder");
    end else begin
      $display("FAIL scrolling_text_display_feeder");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL scrolling_text_display_feeder");
    $finish;
  end

endmodule
